// ===== rtl/npcs_pkg.sv =====
// shared types and constants for the nearest palette color search unit
`default_nettype none

package npcs_pkg;

   localparam int CELL_BITS  = 5;
   localparam int LEVEL_BITS = 8;
   localparam int CELL_SHIFT = LEVEL_BITS - CELL_BITS;
   localparam int SIZE_BITS  = 9;
   localparam int INDEX_BITS = 8;
   localparam int ADDR_BITS  = 3 * CELL_BITS;
   localparam int SQ_BITS    = 2 * LEVEL_BITS;
   localparam int DIST_BITS  = SQ_BITS + 2;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   localparam logic [SIZE_BITS-1:0] PALETTE_SIZE_RESET = 9'd256;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start_query;
      logic write_entry;
      logic scan_step;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic last_issue;
      logic pipe_done;
      logic out_busy;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/npcs_ctrl.sv =====
// controller state machine for the palette search
`default_nettype none

module npcs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_action,
   output logic                      req_stall,
   output npcs_pkg::cmd_type         cmd,
   input  wire npcs_pkg::status_type status
);

   npcs_pkg::state_type state_ff;
   npcs_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= npcs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         npcs_pkg::ST_IDLE: begin
            if (req_valid && (req_action == npcs_pkg::ACTION_QUERY)) begin
               state_in = npcs_pkg::ST_SCAN;
            end
         end
         npcs_pkg::ST_SCAN: begin
            if (status.last_issue) begin
               state_in = npcs_pkg::ST_DRAIN;
            end
         end
         npcs_pkg::ST_DRAIN: begin
            if (status.pipe_done) begin
               state_in = npcs_pkg::ST_DONE;
            end
         end
         npcs_pkg::ST_DONE: begin
            if (!status.out_busy) begin
               state_in = npcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = npcs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall       = (state_ff != npcs_pkg::ST_IDLE);
      cmd.start_query = (state_ff == npcs_pkg::ST_IDLE) && req_valid
                        && (req_action == npcs_pkg::ACTION_QUERY);
      cmd.write_entry = (state_ff == npcs_pkg::ST_IDLE) && req_valid
                        && (req_action == npcs_pkg::ACTION_WRITE);
      cmd.scan_step   = (state_ff == npcs_pkg::ST_SCAN);
      cmd.load_result = (state_ff == npcs_pkg::ST_DONE) && !status.out_busy;
   end

endmodule

`default_nettype wire

// ===== rtl/npcs_datapath.sv =====
// palette memory, distance pipeline, best tracking and result register
`default_nettype none

module npcs_datapath #(
   parameter int PALETTE_DEPTH = 256
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire npcs_pkg::cmd_type                     cmd,
   output npcs_pkg::status_type                       status,
   input  wire logic                                  csr_wr_en,
   input  wire logic [npcs_pkg::SIZE_BITS-1:0]        csr_wr_data,
   input  wire logic [npcs_pkg::INDEX_BITS-1:0]       req_entry_index,
   input  wire logic [npcs_pkg::LEVEL_BITS-1:0]       req_entry_red,
   input  wire logic [npcs_pkg::LEVEL_BITS-1:0]       req_entry_green,
   input  wire logic [npcs_pkg::LEVEL_BITS-1:0]       req_entry_blue,
   input  wire logic [npcs_pkg::CELL_BITS-1:0]        req_cell_red,
   input  wire logic [npcs_pkg::CELL_BITS-1:0]        req_cell_green,
   input  wire logic [npcs_pkg::CELL_BITS-1:0]        req_cell_blue,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [npcs_pkg::INDEX_BITS-1:0]            rsp_nearest_index,
   output logic [npcs_pkg::ADDR_BITS-1:0]             rsp_cell_address
);

   localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int CW    = npcs_pkg::LEVEL_BITS;
   localparam int SW    = npcs_pkg::SIZE_BITS;
   localparam logic [SW-1:0] DEPTH_SZ = SW'(PALETTE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_MAX = IDX_W'(PALETTE_DEPTH - 1);

   // palette storage
   logic [3*CW-1:0] mem [0:PALETTE_DEPTH-1];
   logic [3*CW-1:0] rdata_ff;

   logic [SW-1:0]    palette_size_ff;
   logic [IDX_W-1:0] cnt_ff;
   logic [IDX_W-1:0] last_ff;
   logic [IDX_W-1:0] last_in;

   logic [npcs_pkg::CELL_BITS-1:0] cell_red_ff;
   logic [npcs_pkg::CELL_BITS-1:0] cell_green_ff;
   logic [npcs_pkg::CELL_BITS-1:0] cell_blue_ff;

   logic             s1_valid_ff;
   logic             s1_last_ff;
   logic [IDX_W-1:0] s1_idx_ff;

   logic                          s2_valid_ff;
   logic                          s2_last_ff;
   logic [IDX_W-1:0]              s2_idx_ff;
   logic [npcs_pkg::SQ_BITS-1:0]  sq_red_ff;
   logic [npcs_pkg::SQ_BITS-1:0]  sq_green_ff;
   logic [npcs_pkg::SQ_BITS-1:0]  sq_blue_ff;

   logic [npcs_pkg::DIST_BITS-1:0] best_dist_ff;
   logic [IDX_W-1:0]               best_idx_ff;
   logic [npcs_pkg::DIST_BITS-1:0] dist_sum;

   logic                            rsp_valid_ff;
   logic [npcs_pkg::INDEX_BITS-1:0] rsp_index_ff;
   logic [npcs_pkg::ADDR_BITS-1:0]  rsp_addr_ff;

   logic [CW-1:0] ref_red;
   logic [CW-1:0] ref_green;
   logic [CW-1:0] ref_blue;
   logic [CW-1:0] pal_red;
   logic [CW-1:0] pal_green;
   logic [CW-1:0] pal_blue;
   logic [CW-1:0] diff_red;
   logic [CW-1:0] diff_green;
   logic [CW-1:0] diff_blue;
   logic          entry_in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         palette_size_ff <= npcs_pkg::PALETTE_SIZE_RESET;
      end else if (csr_wr_en) begin
         palette_size_ff <= csr_wr_data;
      end
   end

   assign entry_in_range = ({1'b0, req_entry_index} < DEPTH_SZ);

   always_ff @(posedge clock) begin
      if (cmd.write_entry && entry_in_range) begin
         mem[req_entry_index[IDX_W-1:0]] <= {req_entry_red, req_entry_green, req_entry_blue};
      end
   end

   always_ff @(posedge clock) begin
      rdata_ff <= mem[cnt_ff];
   end

   // search length saturated to one through the palette depth
   always_comb begin
      priority if (palette_size_ff == '0) begin
         last_in = '0;
      end else if (palette_size_ff > DEPTH_SZ) begin
         last_in = LAST_MAX;
      end else begin
         last_in = IDX_W'(palette_size_ff - SW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_query) begin
         last_ff       <= last_in;
         cell_red_ff   <= req_cell_red;
         cell_green_ff <= req_cell_green;
         cell_blue_ff  <= req_cell_blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.start_query) begin
         cnt_ff <= '0;
      end else if (cmd.scan_step) begin
         cnt_ff <= cnt_ff + IDX_W'(1);
      end
   end

   assign status.last_issue = (cnt_ff == last_ff);

   // stage 1: registered read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_last_ff  <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.scan_step;
         s1_last_ff  <= cmd.scan_step && status.last_issue;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= cnt_ff;
   end

   // stage 2: squared component differences
   assign ref_red   = {cell_red_ff, npcs_pkg::CELL_SHIFT'(0)};
   assign ref_green = {cell_green_ff, npcs_pkg::CELL_SHIFT'(0)};
   assign ref_blue  = {cell_blue_ff, npcs_pkg::CELL_SHIFT'(0)};
   assign pal_red   = rdata_ff[3*CW-1:2*CW];
   assign pal_green = rdata_ff[2*CW-1:CW];
   assign pal_blue  = rdata_ff[CW-1:0];

   assign diff_red   = (pal_red > ref_red) ? (pal_red - ref_red) : (ref_red - pal_red);
   assign diff_green = (pal_green > ref_green) ? (pal_green - ref_green)
                                               : (ref_green - pal_green);
   assign diff_blue  = (pal_blue > ref_blue) ? (pal_blue - ref_blue) : (ref_blue - pal_blue);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s2_last_ff  <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
         s2_last_ff  <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_idx_ff   <= s1_idx_ff;
      sq_red_ff   <= npcs_pkg::SQ_BITS'(diff_red * diff_red);
      sq_green_ff <= npcs_pkg::SQ_BITS'(diff_green * diff_green);
      sq_blue_ff  <= npcs_pkg::SQ_BITS'(diff_blue * diff_blue);
   end

   // stage 3: sum and compare, strict less keeps the lowest index on ties
   assign dist_sum = npcs_pkg::DIST_BITS'(sq_red_ff) + npcs_pkg::DIST_BITS'(sq_green_ff)
                   + npcs_pkg::DIST_BITS'(sq_blue_ff);

   always_ff @(posedge clock) begin
      if (cmd.start_query) begin
         best_dist_ff <= '1;
         best_idx_ff  <= '0;
      end else if (s2_valid_ff && (dist_sum < best_dist_ff)) begin
         best_dist_ff <= dist_sum;
         best_idx_ff  <= s2_idx_ff;
      end
   end

   assign status.pipe_done = s2_valid_ff && s2_last_ff;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         rsp_index_ff <= npcs_pkg::INDEX_BITS'(best_idx_ff);
         rsp_addr_ff  <= {cell_red_ff, cell_green_ff, cell_blue_ff};
      end
   end

   assign status.out_busy   = rsp_valid_ff && rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_nearest_index = rsp_index_ff;
   assign rsp_cell_address  = rsp_addr_ff;

endmodule

`default_nettype wire

// ===== rtl/nearest_palette_color_search_unit.sv =====
// top level of the nearest palette color search unit
//
// A write transfer stores one palette entry if its index is below PALETTE_DEPTH. A
// query transfer scans entries 0 to palette_size-1 (saturated to 1..PALETTE_DEPTH)
// through one distance unit fed from a palette memory with separate write and read
// ports, one entry per cycle, and stalls the input until its result is loaded. The
// result sits in an output register; the next transfer is taken while it waits, and
// a finished search only holds if the previous result is still stalled. Palette
// entries that were never written read back as arbitrary values.
`default_nettype none

module nearest_palette_color_search_unit #(
   parameter int PALETTE_DEPTH = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_wr_en,
   input  wire logic [npcs_pkg::SIZE_BITS-1:0]     csr_wr_data,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_action,
   input  wire logic [npcs_pkg::INDEX_BITS-1:0]    req_entry_index,
   input  wire logic [npcs_pkg::LEVEL_BITS-1:0]    req_entry_red,
   input  wire logic [npcs_pkg::LEVEL_BITS-1:0]    req_entry_green,
   input  wire logic [npcs_pkg::LEVEL_BITS-1:0]    req_entry_blue,
   input  wire logic [npcs_pkg::CELL_BITS-1:0]     req_cell_red,
   input  wire logic [npcs_pkg::CELL_BITS-1:0]     req_cell_green,
   input  wire logic [npcs_pkg::CELL_BITS-1:0]     req_cell_blue,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [npcs_pkg::INDEX_BITS-1:0]         rsp_nearest_index,
   output logic [npcs_pkg::ADDR_BITS-1:0]          rsp_cell_address
);

   npcs_pkg::cmd_type    cmd;
   npcs_pkg::status_type status;

   npcs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .cmd        (cmd),
      .status     (status)
   );

   npcs_datapath #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_entry_index   (req_entry_index),
      .req_entry_red     (req_entry_red),
      .req_entry_green   (req_entry_green),
      .req_entry_blue    (req_entry_blue),
      .req_cell_red      (req_cell_red),
      .req_cell_green    (req_cell_green),
      .req_cell_blue     (req_cell_blue),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_nearest_index (rsp_nearest_index),
      .rsp_cell_address  (rsp_cell_address)
   );

endmodule

`default_nettype wire
